FILE: rtl/core/tlbd_pkg.sv
// Shared constants, types and table builders for the two-level derivative core.
package tlbd_pkg;

    // Logarithm: one fraction bit per stage plus a normalising stage.
    localparam int LOG_FRAC = 24;
    localparam int LOG_LAT = LOG_FRAC + 1;
    localparam int NEG_L_W = 5 + LOG_FRAC;

    // Exponential: an entry stage, one stage per fraction bit and a shift stage.
    localparam int EXP_STEPS = 32;
    localparam int EXP_LAT = EXP_STEPS + 2;
    localparam int Z_W = 45;
    localparam int U_W = 33;

    // Capture, sawtooth, log, power, exp, switch product, scale, exp, drive, rounding, terms.
    localparam int PIPE_DEPTH = 2 + LOG_LAT + 1 + EXP_LAT + 2 + EXP_LAT + 3;

    localparam logic [31:0] LOG2E_Q31 = 32'hB8AA3B29;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RABI_FREQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_POWER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETUNE_AMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DETUNE_FREQ = 3'd4;

    typedef logic [EXP_STEPS:0][31:0] pow_tab_t;

    // Data that travels alongside the drive computation.
    typedef struct packed {
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic signed [31:0] er;
        logic signed [31:0] ei;
        logic signed [32:0] dt;
        logic               zero;
    } sb_t;

    // One finished request.
    typedef struct packed {
        logic [7:0][31:0] d;
        logic             sat;
    } res_t;

    // Integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Table of 2^(-2^-k) in Q0.32 built by repeated square roots.
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t    t;
        logic [63:0] v;
        v = 64'h8000_0000;
        t[0] = v[31:0];
        for (int k = 1; k <= EXP_STEPS; k++)
        begin
            v = isqrt64(v << 32);
            t[k] = v[31:0];
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

FILE: rtl/core/tlbd_log2_unit.sv
// Pipelined base-two logarithm of a Q0.31 magnitude, one fraction bit per stage.
module tlbd_log2_unit (
    input  logic                          clk,
    input  logic                          en,
    input  logic [31:0]                   w,
    output logic [tlbd_pkg::NEG_L_W-1:0]  neg_l
);
    import tlbd_pkg::*;

    logic [31:0]         m_reg  [LOG_LAT];
    logic [4:0]          e_reg  [LOG_LAT];
    logic [LOG_FRAC-1:0] fr_reg [LOG_LAT];

    logic [4:0]          e0;
    logic [31:0]         m0;
    logic [63:0]         sq      [1:LOG_LAT-1];
    logic [31:0]         m_next  [1:LOG_LAT-1];
    logic [LOG_FRAC-1:0] fr_next [1:LOG_LAT-1];

    // Leading one and normalisation of the mantissa into Q1.31.
    always_comb
    begin
        e0 = '0;
        for (int i = 1; i < 32; i++)
        begin
            if (w[i])
            begin
                e0 = 5'(i);
            end
        end
        m0 = w << (5'd31 - e0);
    end

    // Each stage squares the mantissa and takes one fraction bit.
    always_comb
    begin
        for (int s = 1; s < LOG_LAT; s++)
        begin
            sq[s] = {32'b0, m_reg[s-1]} * {32'b0, m_reg[s-1]};
            m_next[s] = sq[s][63] ? sq[s][63:32] : sq[s][62:31];
            fr_next[s] = fr_reg[s-1];
            fr_next[s][LOG_LAT-1-s] = sq[s][63];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= m0;
            e_reg[0] <= e0;
            fr_reg[0] <= '0;
            for (int s = 1; s < LOG_LAT; s++)
            begin
                m_reg[s] <= m_next[s];
                e_reg[s] <= e_reg[s-1];
                fr_reg[s] <= fr_next[s];
            end
        end
    end

    // Negated logarithm, non-negative for magnitudes up to one.
    assign neg_l = {5'd31 - e_reg[LOG_LAT-1], {LOG_FRAC{1'b0}}}
                   - {5'b0, fr_reg[LOG_LAT-1]};

endmodule

FILE: rtl/core/tlbd_exp2_unit.sv
// Pipelined 2^-z for unsigned Q.32 z, one fraction bit per stage.
module tlbd_exp2_unit (
    input  logic                      clk,
    input  logic                      en,
    input  logic [tlbd_pkg::Z_W-1:0]  z,
    output logic [tlbd_pkg::U_W-1:0]  u
);
    import tlbd_pkg::*;

    logic [31:0]    f_reg    [EXP_STEPS];
    logic [U_W-1:0] r_reg    [EXP_STEPS+1];
    logic [5:0]     n_reg    [EXP_STEPS+1];
    logic           over_reg [EXP_STEPS+1];
    logic [U_W-1:0] u_reg;

    logic [Z_W-33:0] n_in;
    logic [64:0]     rnd    [1:EXP_STEPS];
    logic [U_W-1:0]  r_next [1:EXP_STEPS];

    assign n_in = z[Z_W-1:32];

    // Conditional rounded multiply by the table entry of each set fraction bit.
    always_comb
    begin
        for (int k = 1; k <= EXP_STEPS; k++)
        begin
            rnd[k] = {32'b0, r_reg[k-1]} * {33'b0, POW_TAB[k]} + 65'h0_8000_0000;
            r_next[k] = f_reg[k-1][EXP_STEPS-k] ? rnd[k][64:32] : r_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[0] <= z[31:0];
            r_reg[0] <= {1'b1, 32'b0};
            n_reg[0] <= n_in[5:0];
            over_reg[0] <= (n_in > (Z_W-32)'(EXP_STEPS));
            for (int k = 1; k <= EXP_STEPS; k++)
            begin
                r_reg[k] <= r_next[k];
                n_reg[k] <= n_reg[k-1];
                over_reg[k] <= over_reg[k-1];
            end
            for (int k = 1; k < EXP_STEPS; k++)
            begin
                f_reg[k] <= f_reg[k-1];
            end
            // Integer part of z is a right shift.
            u_reg <= over_reg[EXP_STEPS] ? '0 : (r_reg[EXP_STEPS] >> n_reg[EXP_STEPS]);
        end
    end

    assign u = u_reg;

endmodule

FILE: rtl/core/two_level_bloch_derivative_core.sv
// Top level of the two-level master-equation derivative core.
// A request (time and 2x2 density matrix) is accepted every clock while in_stall is low;
// throughput is one per clock while nothing stalls. The depth comes from the
// 25-stage logarithm and the two 34-stage exponentials of the soft-switched drive, most
// stages holding one multiplier. A two-entry output buffer keeps results while out_stall
// is high; in_stall rises only when its second entry fills. Configuration is written
// through the cfg port, always ready, and must only change while no request is in flight.
module two_level_bloch_derivative_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [47:0]                       time_now,
    input  logic signed [31:0]                g_g_re,
    input  logic signed [31:0]                g_g_im,
    input  logic signed [31:0]                g_e_re,
    input  logic signed [31:0]                g_e_im,
    input  logic signed [31:0]                e_g_re,
    input  logic signed [31:0]                e_g_im,
    input  logic signed [31:0]                e_e_re,
    input  logic signed [31:0]                e_e_im,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                dg_g_re,
    output logic signed [31:0]                dg_g_im,
    output logic signed [31:0]                dg_e_re,
    output logic signed [31:0]                dg_e_im,
    output logic signed [31:0]                de_g_re,
    output logic signed [31:0]                de_g_im,
    output logic signed [31:0]                de_e_re,
    output logic signed [31:0]                de_e_im,
    output logic                              saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import tlbd_pkg::*;

    localparam logic signed [40:0] SAT_MAX = 41'sd2147483647;
    localparam logic signed [40:0] SAT_MIN = -41'sd2147483648;

    // Configuration registers.
    logic signed [31:0] rabi_freq_reg;
    logic [31:0]        switch_coeff_reg;
    logic [15:0]        switch_power_reg;
    logic signed [31:0] detune_amp_reg;
    logic [31:0]        detune_freq_reg;

    // Pipeline control.
    logic                  advance;
    logic [PIPE_DEPTH-1:0] valid_reg;

    // Sawtooth stages.
    logic [31:0]        frac_reg;
    sb_t                sb_a;
    sb_t                sb_b;
    logic signed [63:0] sprod_reg;
    logic [31:0]        w_reg;

    // Side data across the long units.
    sb_t sb_log [LOG_LAT];
    sb_t sb_z;
    sb_t sb_e1  [EXP_LAT];
    sb_t sb_x;
    sb_t sb_y;
    sb_t sb_e2  [EXP_LAT];
    sb_t sb_r;
    sb_t sb_q;
    sb_t sb_p;

    logic [Z_W-1:0]     z_reg;
    logic [63:0]        x_reg;
    logic [Z_W-1:0]     y_reg;
    logic signed [65:0] rp_reg;
    logic signed [32:0] rr_reg;
    logic signed [49:0] p1_reg;
    logic signed [49:0] p2_reg;
    logic signed [49:0] p3_reg;
    logic signed [49:0] p4_reg;
    logic signed [49:0] qbi_reg;
    logic signed [49:0] qbr_reg;
    logic signed [49:0] qci_reg;
    logic signed [49:0] qcr_reg;

    // Output buffer.
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic out_valid_next;
    logic skid_valid_next;
    logic load_out_pipe;
    logic load_out_skid;
    logic load_skid;
    logic emit;
    logic take;
    res_t res_next;

    // Combinational intermediates.
    logic [63:0]          fprod;
    logic signed [31:0]   s_val;
    logic signed [32:0]   s_wide;
    logic [32:0]          s_abs;
    sb_t                  sb_b_next;
    sb_t                  sb_c_next;
    logic signed [63:0]   dt_sum;
    logic [NEG_L_W-1:0]   neg_l;
    logic [U_W-1:0]       u1;
    logic [U_W-1:0]       u_m;
    logic [U_W-1:0]       sw;
    logic [63:0]          x_next;
    logic                 big;
    logic [61:0]          yp;
    logic [Z_W-1:0]       y_next;
    logic signed [65:0]   rr_sum;
    logic signed [32:0]   d_bc_i;
    logic signed [32:0]   d_bc_r;
    logic signed [32:0]   d_ae_r;
    logic signed [32:0]   d_ae_i;
    logic signed [65:0]   m1;
    logic signed [65:0]   m2;
    logic signed [65:0]   m3;
    logic signed [65:0]   m4;
    logic signed [64:0]   n_bi;
    logic signed [64:0]   n_br;
    logic signed [64:0]   n_ci;
    logic signed [64:0]   n_cr;
    logic signed [55:0]   acc [8];
    logic [32:0]          fin [8];

    // Round from Q.31 to Q16.16 and clamp; the top bit flags a clamp.
    function automatic logic [32:0] finish(input logic signed [55:0] q);
        logic signed [55:0] r;
        logic signed [40:0] v;
        r = q + 56'sd16384;
        v = 41'(r >>> 15);
        if (v > SAT_MAX)
        begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < SAT_MIN)
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rabi_freq_reg <= 32'sd65536;
            switch_coeff_reg <= '0;
            switch_power_reg <= 16'd512;
            detune_amp_reg <= '0;
            detune_freq_reg <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RABI_FREQ:    rabi_freq_reg <= cfg_data;
                CFG_SWITCH_COEFF: switch_coeff_reg <= cfg_data;
                CFG_SWITCH_POWER: switch_power_reg <= cfg_data[15:0];
                CFG_DETUNE_AMP:   detune_amp_reg <= cfg_data;
                CFG_DETUNE_FREQ:  detune_freq_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The whole pipeline moves unless the output buffer is full.
    assign advance = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // Sawtooth phase, its sign-centred value and magnitude.
    always_comb
    begin
        fprod = {32'b0, detune_freq_reg} * {32'b0, time_now[31:0]};
        s_val = {~frac_reg[31], frac_reg[30:0]};
        s_wide = s_val;
        s_abs = s_wide[32] ? -s_wide : s_wide;
        sb_b_next = sb_a;
        sb_b_next.zero = (s_val == 32'sd0);
        dt_sum = sprod_reg + 64'sd1073741824;
        sb_c_next = sb_b;
        sb_c_next.dt = dt_sum[63:31];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frac_reg <= fprod[31:0];
            sb_a.ar <= g_g_re;
            sb_a.ai <= g_g_im;
            sb_a.br <= g_e_re;
            sb_a.bi <= g_e_im;
            sb_a.cr <= e_g_re;
            sb_a.ci <= e_g_im;
            sb_a.er <= e_e_re;
            sb_a.ei <= e_e_im;
            sb_a.dt <= '0;
            sb_a.zero <= 1'b0;

            sprod_reg <= detune_amp_reg * s_val;
            w_reg <= s_abs[31:0];
            sb_b <= sb_b_next;

            sb_log[0] <= sb_c_next;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                sb_log[i] <= sb_log[i-1];
            end
        end
    end

    tlbd_log2_unit u_log (
        .clk   (clk),
        .en    (advance),
        .w     (w_reg),
        .neg_l (neg_l)
    );

    // Power: |s|^p exponent in Q.32.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            z_reg <= {16'b0, neg_l} * {{(Z_W-16){1'b0}}, switch_power_reg};
            sb_z <= sb_log[LOG_LAT-1];
            sb_e1[0] <= sb_z;
            for (int i = 1; i < EXP_LAT; i++)
            begin
                sb_e1[i] <= sb_e1[i-1];
            end
        end
    end

    tlbd_exp2_unit u_exp_pow (
        .clk (clk),
        .en  (advance),
        .z   (z_reg),
        .u   (u1)
    );

    // Switch exponent c*|s|^p scaled by log2(e), or forced huge beyond 64.
    always_comb
    begin
        u_m = sb_e1[EXP_LAT-1].zero ? '0 : u1;
        x_next = {32'b0, switch_coeff_reg} * {31'b0, u_m};
        big = |x_reg[63:54];
        yp = {32'b0, x_reg[53:24]} * {30'b0, LOG2E_Q31};
        y_next = big ? '1 : {6'b0, yp[61:23]};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            sb_x <= sb_e1[EXP_LAT-1];
            y_reg <= y_next;
            sb_y <= sb_x;
            sb_e2[0] <= sb_y;
            for (int i = 1; i < EXP_LAT; i++)
            begin
                sb_e2[i] <= sb_e2[i-1];
            end
        end
    end

    tlbd_exp2_unit u_exp_sw (
        .clk (clk),
        .en  (advance),
        .z   (y_reg),
        .u   (sw)
    );

    // Drive amplitude, coherence differences and the product terms.
    always_comb
    begin
        rr_sum = rp_reg + 66'sd2147483648;
        d_bc_i = sb_q.bi - sb_q.ci;
        d_bc_r = sb_q.br - sb_q.cr;
        d_ae_r = sb_q.ar - sb_q.er;
        d_ae_i = sb_q.ai - sb_q.ei;
        m1 = rr_reg * d_bc_i;
        m2 = rr_reg * d_bc_r;
        m3 = rr_reg * d_ae_r;
        m4 = rr_reg * d_ae_i;
        n_bi = sb_q.dt * sb_q.bi;
        n_br = sb_q.dt * sb_q.br;
        n_ci = sb_q.dt * sb_q.ci;
        n_cr = sb_q.dt * sb_q.cr;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rp_reg <= rabi_freq_reg * $signed({1'b0, sw});
            sb_r <= sb_e2[EXP_LAT-1];
            rr_reg <= rr_sum[64:32];
            sb_q <= sb_r;
            p1_reg <= m1[65:16];
            p2_reg <= m2[65:16];
            p3_reg <= m3[65:16];
            p4_reg <= m4[65:16];
            qbi_reg <= n_bi[64:15];
            qbr_reg <= n_br[64:15];
            qci_reg <= n_ci[64:15];
            qcr_reg <= n_cr[64:15];
            sb_p <= sb_q;
        end
    end

    // Final sums in Q.31, rounding and saturation.
    always_comb
    begin
        acc[0] = 56'sd2 * sb_p.er - p1_reg;
        acc[1] = 56'sd2 * sb_p.ei + p2_reg;
        acc[2] = -sb_p.br - p4_reg + qbi_reg;
        acc[3] = -sb_p.bi + p3_reg - qbr_reg;
        acc[4] = -sb_p.cr + p4_reg - qci_reg;
        acc[5] = -sb_p.ci - p3_reg + qcr_reg;
        acc[6] = -56'sd2 * sb_p.er + p1_reg;
        acc[7] = -56'sd2 * sb_p.ei - p2_reg;
        res_next.sat = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            fin[i] = finish(acc[i]);
            res_next.d[i] = fin[i][31:0];
            res_next.sat = res_next.sat | fin[i][32];
        end
    end

    // Output register with one skid entry behind it.
    assign emit = valid_reg[PIPE_DEPTH-1] && advance;
    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_pipe = 1'b0;
        load_out_skid = 1'b0;
        load_skid = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_out_skid = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || take)
            begin
                load_out_pipe = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_pipe)
        begin
            out_reg <= res_next;
        end
        else if (load_out_skid)
        begin
            out_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign dg_g_re = out_reg.d[0];
    assign dg_g_im = out_reg.d[1];
    assign dg_e_re = out_reg.d[2];
    assign dg_e_im = out_reg.d[3];
    assign de_g_re = out_reg.d[4];
    assign de_g_im = out_reg.d[5];
    assign de_e_re = out_reg.d[6];
    assign de_e_im = out_reg.d[7];
    assign saturated = out_reg.sat;

endmodule

FILE: rtl/core/tlbd_checker.sv
// Port-level checks for the derivative core, bound to its top level.
module tlbd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [47:0]                       time_now,
    input logic signed [31:0]                g_g_re,
    input logic signed [31:0]                g_g_im,
    input logic signed [31:0]                g_e_re,
    input logic signed [31:0]                g_e_im,
    input logic signed [31:0]                e_g_re,
    input logic signed [31:0]                e_g_im,
    input logic signed [31:0]                e_e_re,
    input logic signed [31:0]                e_e_im,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [31:0]                dg_g_re,
    input logic signed [31:0]                dg_g_im,
    input logic signed [31:0]                dg_e_re,
    input logic signed [31:0]                dg_e_im,
    input logic signed [31:0]                de_g_re,
    input logic signed [31:0]                de_g_im,
    input logic signed [31:0]                de_e_re,
    input logic signed [31:0]                de_e_im,
    input logic                              saturated,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [tlbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [31:0]                       cfg_data
);

    // The input only stalls once a result has been held back.
    property p_stall_cause;
        @(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall);
    endproperty
    a_stall_cause: assert property (p_stall_cause)
        else $error("input stalled without a held result");

    // A stalled input is released in the cycle after the held result is taken.
    property p_stall_release;
        @(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall;
    endproperty
    a_stall_release: assert property (p_stall_release)
        else $error("input stall held after output was taken");

    // A stalled input means a result is on show.
    property p_stall_shows;
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid;
    endproperty
    a_stall_shows: assert property (p_stall_shows)
        else $error("input stalled with no result presented");

    // A clamp flag always comes with at least one field at a rail.
    property p_sat_rail;
        @(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (dg_g_re == 32'sh7FFF_FFFF) || (dg_g_re == 32'sh8000_0000) ||
            (dg_g_im == 32'sh7FFF_FFFF) || (dg_g_im == 32'sh8000_0000) ||
            (dg_e_re == 32'sh7FFF_FFFF) || (dg_e_re == 32'sh8000_0000) ||
            (dg_e_im == 32'sh7FFF_FFFF) || (dg_e_im == 32'sh8000_0000) ||
            (de_g_re == 32'sh7FFF_FFFF) || (de_g_re == 32'sh8000_0000) ||
            (de_g_im == 32'sh7FFF_FFFF) || (de_g_im == 32'sh8000_0000) ||
            (de_e_re == 32'sh7FFF_FFFF) || (de_e_re == 32'sh8000_0000) ||
            (de_e_im == 32'sh7FFF_FFFF) || (de_e_im == 32'sh8000_0000);
    endproperty
    a_sat_rail: assert property (p_sat_rail)
        else $error("saturated flag without a clamped field");

    // A held result stays on the port; only dg_g_re and the saturated flag are compared.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dg_g_re) && $stable(saturated);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed");

endmodule

bind two_level_bloch_derivative_core tlbd_checker u_tlbd_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the two-level master-equation derivative core.
`timescale 1ns / 100ps

module tb;
    import tlbd_pkg::*;

    // One request: time and the eight density-matrix words in port order.
    typedef struct packed {
        logic [47:0]      t;
        logic [7:0][31:0] m;
    } rho_req_t;

    // One derivative result.
    typedef struct packed {
        logic [7:0][31:0] d;
        logic             sat;
    } deriv_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [47:0] time_now = '0;
    logic signed [31:0] g_g_re = '0, g_g_im = '0, g_e_re = '0, g_e_im = '0;
    logic signed [31:0] e_g_re = '0, e_g_im = '0, e_e_re = '0, e_e_im = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] dg_g_re, dg_g_im, dg_e_re, dg_e_im;
    logic signed [31:0] de_g_re, de_g_im, de_e_re, de_e_im;
    logic saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RABI_FREQ;
    logic [31:0] cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic signed [31:0] sh_rabi = 32'sd65536;
    logic [31:0] sh_coeff = 32'd0;
    logic [15:0] sh_power = 16'd512;
    logic signed [31:0] sh_amp = 32'sd0;
    logic [31:0] sh_freq = 32'd65536;

    logic [63:0] root_tab [0:32];

    rho_req_t pending_q[$];
    deriv_t   deriv_q[$];
    rho_req_t cur_req;
    int in_gap = 0;
    int stall_cnt = 0;
    int long_cnt = 0;
    bit idle_on = 1'b1;
    logic long_req = 1'b0;
    bit long_done = 1'b0;
    int mismatches = 0;

    two_level_bloch_derivative_core dut (.*);

    always #4 clk = ~clk;

    // Gap length: mostly none, sometimes short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^-z with z in unsigned Q.32, result in Q1.32.
    function automatic logic [63:0] pow2_neg(input logic [63:0] z);
        logic [63:0] r;
        r = 64'd1 << 32;
        if ((z >> 32) > 32)
            return 64'd0;
        for (int k = 1; k <= 32; k++)
            if (z[32-k])
                r = (r * root_tab[k] + (64'd1 << 31)) >> 32;
        return r >> (z >> 32);
    endfunction

    // log2(w / 2^31) in signed Q.24.
    function automatic longint log2_frac(input logic [63:0] w);
        int e;
        logic [63:0] m;
        longint fr;
        e = 0;
        fr = 0;
        while (e < 31 && (w >> (e + 1)) != 0)
            e++;
        m = w << (31 - e);
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                fr = fr | (longint'(1) << i);
                m = m >> 1;
            end
        end
        return (longint'(e) - 31) * (longint'(1) << 24) + fr;
    endfunction

    // Round Q.31 to Q16.16 and clamp to 32 bits.
    function automatic logic [31:0] round_clamp(input longint q, inout logic sat);
        longint v;
        v = (q + (longint'(1) << 14)) >>> 15;
        if (v > 64'sh7FFF_FFFF)
        begin
            v = 64'sh7FFF_FFFF;
            sat = 1'b1;
        end
        else if (v < -64'sh8000_0000)
        begin
            v = -64'sh8000_0000;
            sat = 1'b1;
        end
        return v[31:0];
    endfunction

    // Derivative of the density matrix under the current shadow configuration.
    function automatic deriv_t bloch_deriv(input rho_req_t q);
        deriv_t res;
        logic [63:0] fr, w, u, x, xq, sw;
        longint s, det, drive, lg, p1, p2, p3, p4;
        longint ar, ai, br, bi, cr, ci, er, ei;
        logic sat;
        sat = 1'b0;
        fr = ({32'd0, sh_freq} * {32'd0, q.t[31:0]}) & 64'hFFFF_FFFF;
        s = longint'(fr) - (longint'(1) << 31);
        det = (longint'(sh_amp) * s + (longint'(1) << 30)) >>> 31;
        w = (s < 0) ? -s : s;
        // A zero sawtooth switches the drive fully on.
        if (w == 0)
            u = 0;
        else
        begin
            lg = log2_frac(w);
            u = pow2_neg(64'(-lg) * {48'd0, sh_power});
        end
        x = {32'd0, sh_coeff} * u;
        xq = x >> 24;
        if (xq >= (64'd64 << 24))
            sw = 0;
        else
            sw = pow2_neg((xq * 64'hB8AA3B29) >> 23);
        drive = (longint'(sh_rabi) * longint'(sw) + (longint'(1) << 31)) >>> 32;
        ar = $signed(q.m[0]); ai = $signed(q.m[1]);
        br = $signed(q.m[2]); bi = $signed(q.m[3]);
        cr = $signed(q.m[4]); ci = $signed(q.m[5]);
        er = $signed(q.m[6]); ei = $signed(q.m[7]);
        p1 = (drive * (bi - ci)) >>> 16;
        p2 = (drive * (br - cr)) >>> 16;
        p3 = (drive * (ar - er)) >>> 16;
        p4 = (drive * (ai - ei)) >>> 16;
        res.d[0] = round_clamp(2 * er - p1, sat);
        res.d[1] = round_clamp(2 * ei + p2, sat);
        res.d[2] = round_clamp(-br - p4 + ((det * bi) >>> 15), sat);
        res.d[3] = round_clamp(-bi + p3 - ((det * br) >>> 15), sat);
        res.d[4] = round_clamp(-cr + p4 - ((det * ci) >>> 15), sat);
        res.d[5] = round_clamp(-ci - p3 + ((det * cr) >>> 15), sat);
        res.d[6] = round_clamp(-2 * er + p1, sat);
        res.d[7] = round_clamp(-2 * ei - p2, sat);
        res.sat = sat;
        return res;
    endfunction

    // Matrix word: full range, small, or an extreme.
    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        if (r < 8)
            return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        return (r == 8) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic rho_req_t rand_req();
        rho_req_t q;
        logic [63:0] tt;
        tt = {$urandom, $urandom};
        q.t = ($urandom_range(0, 3) == 0) ? {32'd0, 16'($urandom)} : tt[47:0];
        for (int i = 0; i < 8; i++)
            q.m[i] = rand_word();
        return q;
    endfunction

    // Request driver: one request per handshake, random gaps between while idle_on is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deriv_q.push_back(bloch_deriv(cur_req));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_req = pending_q.pop_front();
                    time_now <= cur_req.t;
                    g_g_re <= cur_req.m[0]; g_g_im <= cur_req.m[1];
                    g_e_re <= cur_req.m[2]; g_e_im <= cur_req.m[3];
                    e_g_re <= cur_req.m[4]; e_g_im <= cur_req.m[5];
                    e_e_re <= cur_req.m[6]; e_e_im <= cur_req.m[7];
                    in_valid <= 1'b1;
                    in_gap = idle_on ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls while idle_on is set and one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (long_req && !long_done)
        begin
            long_done = 1'b1;
            long_cnt = 400;
            out_stall <= 1'b1;
        end
        else if (long_cnt > 0)
        begin
            long_cnt--;
            out_stall <= 1'b1;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_cnt = idle_on ? pick_gap() : 0;
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge clk)
    begin
        deriv_t got;
        deriv_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.d = {de_e_im, de_e_re, de_g_im, de_g_re, dg_e_im, dg_e_re, dg_g_im, dg_g_re};
            got.sat = saturated;
            if (deriv_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = deriv_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        for (int i = 0; i < 8; i++)
                            $display("field %0d: expected %h got %h (sat %b/%b)",
                                     i, want.d[i], got.d[i], want.sat, got.sat);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RABI_FREQ:    sh_rabi = val;
            CFG_SWITCH_COEFF: sh_coeff = val;
            CFG_SWITCH_POWER: sh_power = val[15:0];
            CFG_DETUNE_AMP:   sh_amp = val;
            CFG_DETUNE_FREQ:  sh_freq = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] rabi, input logic [31:0] coeff,
                             input logic [15:0] pw, input logic [31:0] amp,
                             input logic [31:0] freq);
        write_reg(CFG_RABI_FREQ, rabi);
        write_reg(CFG_SWITCH_COEFF, coeff);
        write_reg(CFG_SWITCH_POWER, {16'd0, pw});
        write_reg(CFG_DETUNE_AMP, amp);
        write_reg(CFG_DETUNE_FREQ, freq);
    endtask

    // Wait until nothing is queued or in flight, then let the pipeline empty.
    task automatic drain();
        @(posedge clk);
        while (pending_q.size() > 0 || in_valid || deriv_q.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
    endtask

    task automatic add_random(input int n);
        @(negedge clk);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_req());
    endtask

    // Directed matrices: extremes, zero, and the zero-sawtooth and wrapped times.
    task automatic add_directed();
        rho_req_t q;
        logic [47:0] times [6];
        times = '{48'd0, 48'h8000, 48'hFFFF_FFFF_FFFF, 48'h1_0000_8000,
                  48'h4000, 48'h1_0000};
        @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            q.t = times[i];
            q.m = {8{32'h7FFF_FFFF}};
            pending_q.push_back(q);
            q.m = {8{32'h8000_0000}};
            pending_q.push_back(q);
            q.m = '0;
            pending_q.push_back(q);
            q.m = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
            pending_q.push_back(q);
        end
    endtask

    initial
    begin
        logic [63:0] v;
        v = 64'd1 << 31;
        root_tab[0] = v;
        for (int k = 1; k <= 32; k++)
        begin
            v = int_sqrt(v << 32);
            root_tab[k] = v;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration.
        add_directed();
        add_random(100);
        drain();

        // Positive extremes with the weakest power.
        write_all(32'h7FFF_FFFF, 32'd0, 16'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_directed();
        add_random(100);
        drain();

        // Negative extremes with the largest coefficient and power.
        write_all(32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000, 32'd0);
        add_directed();
        add_random(80);
        drain();

        // Huge switch exponent with a moderate power.
        write_all(32'h0003_0000, 32'h0100_0000, 16'h0100, 32'hFFFE_0000, 32'h0001_8000);
        add_random(120);
        drain();

        // Flood the block while the receiver holds off.
        idle_on = 1'b0;
        write_all(32'h0002_0000, 32'h0000_8000, 16'h0200, 32'h0001_0000, 32'h0000_4000);
        @(negedge clk);
        long_req <= 1'b1;
        add_random(250);
        drain();
        idle_on = 1'b1;

        // Random settings; coefficient and power kept mostly in the useful range.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_all($urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000),
                      16'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 65535 : 2048)),
                      $urandom, $urandom);
            add_random(110);
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
